// File: rtl/core/ppt_pkg.sv
// ppt_pkg: sizes, codes and shared types of the promotable priority table.
// Used by ppt_scan and promotable_priority_table; depends on nothing.
package ppt_pkg;

  localparam int CAPACITY       = 16;
  localparam int PAYLOAD_WIDTH  = 32;
  localparam int PRIORITY_WIDTH = 16;
  localparam int ID_WIDTH       = 32;

  localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int COUNT_W = $clog2(CAPACITY + 1);

  typedef logic [IDX_W-1:0]          idx_t;
  typedef logic [ID_WIDTH-1:0]       id_t;
  typedef logic [PAYLOAD_WIDTH-1:0]  pay_t;
  typedef logic [PRIORITY_WIDTH-1:0] pri_t;
  typedef logic [COUNT_W-1:0]        count_t;

  typedef enum logic [1:0] {
    KIND_ADD,
    KIND_PROMOTE,
    KIND_POP,
    KIND_LOOKUP
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK,
    STATUS_FULL,
    STATUS_UNKNOWN,
    STATUS_EMPTY
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY,
    S_RESCAN,
    S_DONE
  } state_e;

  // control of the shared scan/compare unit
  typedef struct packed {
    logic clear;
    logic scan;
    logic inject;
  } scan_ctl_t;

  // one slot (or a freshly written entry) offered to the compare unit
  typedef struct packed {
    logic used;
    idx_t slot;
    id_t  id;
    pri_t pri;
    pay_t pay;
  } cand_t;

  typedef struct packed {
    logic best_valid;
    idx_t best_slot;
    id_t  best_id;
    pri_t best_pri;
    pay_t best_pay;
    logic free_found;
    idx_t free_slot;
    logic match_found;
    idx_t match_slot;
    pri_t match_pri;
    pay_t match_pay;
  } scan_res_t;

endpackage

// File: rtl/core/promotable_priority_table.sv
// promotable_priority_table: top level with slot storage and the sequencer.
// Depends on ppt_pkg and ppt_scan.
//
// Usage: one request channel (kind, payload, target_id) and one result
// channel, both valid/ready. Each request yields exactly one result
// transaction carrying the operation's outcome, the entry count and the
// current maximum entry after the operation.
// The block handles one request at a time; in_ready_o is high only while
// it is idle. Every request walks all slots once through a single shared
// compare unit, one slot per cycle; a pop walks the slots a second time to
// find the new maximum. The next request is taken in the cycle after the
// result is loaded.
// Results sit in an output register; a stalled receiver holds the result
// while the next request is already accepted and processed, which then
// waits for the output register to free up.
// Reset empties the table and restarts the id counter at zero.
module promotable_priority_table (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  kind_i,
  input  logic [31:0] payload_i,
  input  logic [31:0] target_id_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] result_id_o,
  output logic        found_o,
  output logic [31:0] result_payload_o,
  output logic [15:0] result_priority_o,
  output logic [4:0]  entry_count_o,
  output logic        top_valid_o,
  output logic [31:0] top_payload_o,
  output logic [15:0] top_priority_o
);
  import ppt_pkg::*;

  state_e state_q, state_d;
  idx_t   idx_q, idx_d;

  logic [CAPACITY-1:0] slot_used_q;
  id_t                 slot_id_q       [CAPACITY];
  pay_t                slot_payload_q  [CAPACITY];
  pri_t                slot_priority_q [CAPACITY];

  id_t    next_id_q;
  count_t count_q;

  kind_e  kind_q;
  pay_t   payload_q;
  id_t    target_q;

  status_e res_status_q, res_status_d;
  id_t     res_id_q, res_id_d;
  logic    res_found_q, res_found_d;
  pay_t    res_pay_q, res_pay_d;
  pri_t    res_pri_q, res_pri_d;

  logic    out_valid_q;
  status_e out_status_q;
  id_t     out_id_q;
  logic    out_found_q;
  pay_t    out_pay_q;
  pri_t    out_pri_q;
  count_t  out_count_q;
  logic    out_top_valid_q;
  pay_t    out_top_pay_q;
  pri_t    out_top_pri_q;

  scan_ctl_t scan_ctl;
  cand_t     cand;
  scan_res_t scan_res;

  logic in_fire;
  logic wr_add;
  logic wr_promote;
  logic clr_pop;
  logic out_load;
  pri_t pri_inc;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  // saturating increment of the matched entry's priority
  assign pri_inc = (scan_res.match_pri == '1) ? scan_res.match_pri
                                              : scan_res.match_pri + PRIORITY_WIDTH'(1);

  ppt_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (scan_ctl),
    .cand_i      (cand),
    .target_id_i (target_q),
    .res_o       (scan_res)
  );

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    scan_ctl     = '0;
    cand         = '0;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_found_d  = res_found_q;
    res_pay_d    = res_pay_q;
    res_pri_d    = res_pri_q;
    wr_add       = 1'b0;
    wr_promote   = 1'b0;
    clr_pop      = 1'b0;
    out_load     = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          scan_ctl.clear = 1'b1;
          idx_d          = '0;
          state_d        = S_SCAN;
        end
      end
      S_SCAN, S_RESCAN: begin
        scan_ctl.scan = 1'b1;
        cand.used     = slot_used_q[idx_q];
        cand.slot     = idx_q;
        cand.id       = slot_id_q[idx_q];
        cand.pri      = slot_priority_q[idx_q];
        cand.pay      = slot_payload_q[idx_q];
        if (idx_q == IDX_W'(CAPACITY - 1)) begin
          state_d = (state_q == S_SCAN) ? S_APPLY : S_DONE;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      S_APPLY: begin
        res_status_d = STATUS_OK;
        res_id_d     = '0;
        res_found_d  = 1'b0;
        res_pay_d    = '0;
        res_pri_d    = '0;
        state_d      = S_DONE;
        case (kind_q)
          KIND_ADD: begin
            if (!scan_res.free_found) begin
              res_status_d = STATUS_FULL;
            end else begin
              wr_add          = 1'b1;
              res_id_d        = next_id_q;
              // fold the new entry into the running maximum
              scan_ctl.inject = 1'b1;
              cand.used       = 1'b1;
              cand.slot       = scan_res.free_slot;
              cand.id         = next_id_q;
              cand.pri        = '0;
              cand.pay        = payload_q;
            end
          end
          KIND_PROMOTE: begin
            if (!scan_res.match_found) begin
              res_status_d = STATUS_UNKNOWN;
            end else begin
              wr_promote      = 1'b1;
              res_pri_d       = pri_inc;
              scan_ctl.inject = 1'b1;
              cand.used       = 1'b1;
              cand.slot       = scan_res.match_slot;
              cand.id         = target_q;
              cand.pri        = pri_inc;
              cand.pay        = scan_res.match_pay;
            end
          end
          KIND_POP: begin
            if (!scan_res.best_valid) begin
              res_status_d = STATUS_EMPTY;
            end else begin
              clr_pop        = 1'b1;
              res_id_d       = scan_res.best_id;
              res_pay_d      = scan_res.best_pay;
              res_pri_d      = scan_res.best_pri;
              // second pass finds the maximum among what remains
              scan_ctl.clear = 1'b1;
              idx_d          = '0;
              state_d        = S_RESCAN;
            end
          end
          KIND_LOOKUP: begin
            if (scan_res.match_found) begin
              res_found_d = 1'b1;
              res_pay_d   = scan_res.match_pay;
              res_pri_d   = scan_res.match_pri;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      slot_used_q <= '0;
      next_id_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      if (wr_add) begin
        slot_used_q[scan_res.free_slot] <= 1'b1;
        next_id_q                       <= next_id_q + ID_WIDTH'(1);
        count_q                         <= count_q + COUNT_W'(1);
      end
      if (clr_pop) begin
        slot_used_q[scan_res.best_slot] <= 1'b0;
        count_q                         <= count_q - COUNT_W'(1);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_add) begin
      slot_id_q[scan_res.free_slot]       <= next_id_q;
      slot_payload_q[scan_res.free_slot]  <= payload_q;
      slot_priority_q[scan_res.free_slot] <= '0;
    end
    if (wr_promote) begin
      slot_priority_q[scan_res.match_slot] <= pri_inc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q    <= kind_e'(kind_i);
      payload_q <= PAYLOAD_WIDTH'(payload_i);
      target_q  <= target_id_i;
    end
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_found_q  <= res_found_d;
    res_pay_q    <= res_pay_d;
    res_pri_q    <= res_pri_d;
    if (out_load) begin
      out_status_q    <= res_status_q;
      out_id_q        <= res_id_q;
      out_found_q     <= res_found_q;
      out_pay_q       <= res_pay_q;
      out_pri_q       <= res_pri_q;
      out_count_q     <= count_q;
      out_top_valid_q <= scan_res.best_valid;
      out_top_pay_q   <= scan_res.best_valid ? scan_res.best_pay : '0;
      out_top_pri_q   <= scan_res.best_valid ? scan_res.best_pri : '0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign result_id_o       = out_id_q;
  assign found_o           = out_found_q;
  assign result_payload_o  = 32'(out_pay_q);
  assign result_priority_o = 16'(out_pri_q);
  assign entry_count_o     = 5'(out_count_q);
  assign top_valid_o       = out_top_valid_q;
  assign top_payload_o     = 32'(out_top_pay_q);
  assign top_priority_o    = 16'(out_top_pri_q);

  a_count_matches_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(slot_used_q) == 32'(count_q))
    else $error("entry count disagrees with used slots");

  a_count_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= CAPACITY)
    else $error("entry count above capacity");

  a_top_tracks_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_top_valid_q == (out_count_q != '0)))
    else $error("top entry flag disagrees with entry count");

  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_pop |-> (slot_used_q[scan_res.best_slot] && (count_q != '0)))
    else $error("pop of an empty slot");

endmodule

// File: rtl/core/ppt_scan.sv
// ppt_scan: shared compare unit with its accumulators; one candidate per cycle
// tracks the maximum entry, the lowest free slot and the first id match.
// Depends on ppt_pkg.
module ppt_scan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ppt_pkg::scan_ctl_t ctl_i,
  input  ppt_pkg::cand_t     cand_i,
  input  ppt_pkg::id_t       target_id_i,
  output ppt_pkg::scan_res_t res_o
);
  import ppt_pkg::*;

  scan_res_t res_q;
  logic      key_gt;
  logic      key_eq;
  logic      wins;

  // order: priority, then id; equal keys go to the lower slot
  always_comb begin
    key_gt = (cand_i.pri > res_q.best_pri) ||
             ((cand_i.pri == res_q.best_pri) && (cand_i.id > res_q.best_id));
    key_eq = (cand_i.pri == res_q.best_pri) && (cand_i.id == res_q.best_id);
    wins   = cand_i.used && (!res_q.best_valid || key_gt ||
             (key_eq && (cand_i.slot < res_q.best_slot)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q <= '0;
    end else if (ctl_i.clear) begin
      res_q.best_valid  <= 1'b0;
      res_q.free_found  <= 1'b0;
      res_q.match_found <= 1'b0;
    end else begin
      if ((ctl_i.scan || ctl_i.inject) && wins) begin
        res_q.best_valid <= 1'b1;
        res_q.best_slot  <= cand_i.slot;
        res_q.best_id    <= cand_i.id;
        res_q.best_pri   <= cand_i.pri;
        res_q.best_pay   <= cand_i.pay;
      end
      if (ctl_i.scan && !res_q.free_found && !cand_i.used) begin
        res_q.free_found <= 1'b1;
        res_q.free_slot  <= cand_i.slot;
      end
      if (ctl_i.scan && !res_q.match_found && cand_i.used &&
          (cand_i.id == target_id_i)) begin
        res_q.match_found <= 1'b1;
        res_q.match_slot  <= cand_i.slot;
        res_q.match_pri   <= cand_i.pri;
        res_q.match_pay   <= cand_i.pay;
      end
    end
  end

  assign res_o = res_q;

endmodule

// File: test/ppt_outcome_checker.sv
// ppt_outcome_checker: watches both channels of the promotable priority table,
// predicts each outcome from its own copy of the table and compares it.
// Depends on ppt_pkg for sizes, codes and field types.
module ppt_outcome_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  kind_i,
  input  logic [31:0] payload_i,
  input  logic [31:0] target_id_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [1:0]  status_i,
  input  logic [31:0] result_id_i,
  input  logic        found_i,
  input  logic [31:0] result_payload_i,
  input  logic [15:0] result_priority_i,
  input  logic [4:0]  entry_count_i,
  input  logic        top_valid_i,
  input  logic [31:0] top_payload_i,
  input  logic [15:0] top_priority_i,
  output int          fail_count_o,
  output int          pending_o
);
  import ppt_pkg::*;

  typedef struct packed {
    status_e status;
    id_t     res_id;
    logic    found;
    pay_t    res_pay;
    pri_t    res_pri;
    count_t  count;
    logic    top_valid;
    pay_t    top_pay;
    pri_t    top_pri;
  } outcome_t;

  logic     slot_live [CAPACITY];
  id_t      slot_key  [CAPACITY];
  pay_t     slot_word [CAPACITY];
  pri_t     slot_rank [CAPACITY];
  id_t      id_counter;
  outcome_t awaited_outcomes [$];
  outcome_t want;

  // lowest live slot holding the id
  function automatic int slot_of(id_t key);
    for (int i = 0; i < CAPACITY; i++)
      if (slot_live[i] && slot_key[i] == key) return i;
    return -1;
  endfunction

  // highest priority, then highest id, then lowest slot
  function automatic int top_slot();
    int best;
    best = -1;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!slot_live[i]) continue;
      if (best < 0 || slot_rank[i] > slot_rank[best] ||
          (slot_rank[i] == slot_rank[best] && slot_key[i] > slot_key[best]))
        best = i;
    end
    return best;
  endfunction

  function automatic outcome_t apply_request(kind_e kind, pay_t word, id_t key);
    outcome_t o;
    int s;
    int n;
    o = '0;
    o.status = STATUS_OK;
    case (kind)
      KIND_ADD: begin
        s = -1;
        for (int i = CAPACITY - 1; i >= 0; i--)
          if (!slot_live[i]) s = i;
        if (s < 0) begin
          o.status = STATUS_FULL;
        end else begin
          slot_live[s] = 1'b1;
          slot_key[s]  = id_counter;
          slot_word[s] = word;
          slot_rank[s] = '0;
          o.res_id     = id_counter;
          id_counter   = id_counter + ID_WIDTH'(1);
        end
      end
      KIND_PROMOTE: begin
        s = slot_of(key);
        if (s < 0) begin
          o.status = STATUS_UNKNOWN;
        end else begin
          if (slot_rank[s] != '1) slot_rank[s] = slot_rank[s] + PRIORITY_WIDTH'(1);
          o.res_pri = slot_rank[s];
        end
      end
      KIND_POP: begin
        s = top_slot();
        if (s < 0) begin
          o.status = STATUS_EMPTY;
        end else begin
          o.res_id     = slot_key[s];
          o.res_pay    = slot_word[s];
          o.res_pri    = slot_rank[s];
          slot_live[s] = 1'b0;
        end
      end
      default: begin
        s = slot_of(key);
        if (s >= 0) begin
          o.found   = 1'b1;
          o.res_pay = slot_word[s];
          o.res_pri = slot_rank[s];
        end
      end
    endcase
    n = 0;
    for (int i = 0; i < CAPACITY; i++)
      if (slot_live[i]) n++;
    o.count = count_t'(n);
    s = top_slot();
    if (s >= 0) begin
      o.top_valid = 1'b1;
      o.top_pay   = slot_word[s];
      o.top_pri   = slot_rank[s];
    end
    return o;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) slot_live[i] = 1'b0;
      id_counter = '0;
      awaited_outcomes.delete();
      fail_count_o = 0;
    end else begin
      // the result of an earlier transaction can leave at the same edge a new one enters
      if (out_valid_i && out_ready_i) begin
        if (awaited_outcomes.size() == 0) begin
          $error("result transaction with no request outstanding");
          fail_count_o++;
        end else begin
          want = awaited_outcomes.pop_front();
          check_field("status", 32'(want.status), 32'(status_i));
          check_field("result_id", want.res_id, result_id_i);
          check_field("found", 32'(want.found), 32'(found_i));
          check_field("result_payload", want.res_pay, result_payload_i);
          check_field("result_priority", 32'(want.res_pri), 32'(result_priority_i));
          check_field("entry_count", 32'(want.count), 32'(entry_count_i));
          check_field("top_valid", 32'(want.top_valid), 32'(top_valid_i));
          check_field("top_payload", want.top_pay, top_payload_i);
          check_field("top_priority", 32'(want.top_pri), 32'(top_priority_i));
        end
      end
      if (in_valid_i && in_ready_i)
        awaited_outcomes.push_back(apply_request(kind_e'(kind_i), payload_i, target_id_i));
    end
    pending_o = awaited_outcomes.size();
  end

endmodule

// File: test/promotable_priority_table_tb.sv
// promotable_priority_table_tb: drives requests into the table with bursty
// pacing and a stalling receiver, and gives the verdict.
// Depends on ppt_pkg, promotable_priority_table and ppt_outcome_checker.
module promotable_priority_table_tb;
  import ppt_pkg::*;

  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int BLOCKS      = 9;
  localparam int BLOCK_ITEMS = 100;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [1:0]  kind_i      = KIND_ADD;
  logic [31:0] payload_i   = '0;
  logic [31:0] target_id_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] result_id_o;
  logic        found_o;
  logic [31:0] result_payload_o;
  logic [15:0] result_priority_o;
  logic [4:0]  entry_count_o;
  logic        top_valid_o;
  logic [31:0] top_payload_o;
  logic [15:0] top_priority_o;

  int fail_count;
  int pending;
  int cycle_count = 0;
  int burst_left  = 0;
  int add_count   = 0;
  int rx_left     = 0;
  bit rx_open     = 1'b0;
  bit pace_en     = 1'b1;
  bit rx_stall_en = 1'b1;

  always #1 clk_i = ~clk_i;

  promotable_priority_table u_top (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o, .kind_i, .payload_i, .target_id_i,
    .out_valid_o, .out_ready_i,
    .status_o, .result_id_o, .found_o, .result_payload_o, .result_priority_o,
    .entry_count_o, .top_valid_o, .top_payload_o, .top_priority_o
  );

  ppt_outcome_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .payload_i, .target_id_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .status_i(status_o), .result_id_i(result_id_o), .found_i(found_o),
    .result_payload_i(result_payload_o), .result_priority_i(result_priority_o),
    .entry_count_i(entry_count_o), .top_valid_i(top_valid_o),
    .top_payload_i(top_payload_o), .top_priority_i(top_priority_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // receiver: alternating open and stalled stretches, sometimes long open runs
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_open = !rx_open;
        if (rx_open) begin
          rx_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300)
                                                : $urandom_range(1, 20);
        end else begin
          rx_left = $urandom_range(1, 45);
        end
      end
      rx_left--;
      out_ready_i <= rx_open || !rx_stall_en;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // valid stays high across a burst; the next request is issued in the same step
  task automatic send_request(kind_e kind, pay_t word, id_t key);
    int gap;
    if (burst_left == 0) begin
      if (pace_en) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 6);
        burst_left = $urandom_range(1, 12);
      end else begin
        gap = 1;
        burst_left = 1 << 30;
      end
      repeat (gap) @(posedge clk_i);
    end
    kind_i      <= kind;
    payload_i   <= word;
    target_id_i <= key;
    in_valid_i  <= 1'b1;
    if (kind == KIND_ADD) add_count++;
    do @(posedge clk_i); while (!in_ready_o);
    burst_left--;
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  task automatic end_burst();
    if (burst_left != 0) begin
      burst_left = 0;
      in_valid_i <= 1'b0;
    end
  endtask

  // ids are aimed mostly at the recently issued range so promotes and lookups hit
  task automatic random_request(int add_w, int promote_w, int pop_w);
    int   r;
    int   lo;
    kind_e kind;
    pay_t word;
    id_t  key;
    r = $urandom_range(0, 99);
    if (r < add_w) kind = KIND_ADD;
    else if (r < add_w + promote_w) kind = KIND_PROMOTE;
    else if (r < add_w + promote_w + pop_w) kind = KIND_POP;
    else kind = KIND_LOOKUP;
    case ($urandom_range(0, 7))
      0:       word = '0;
      1:       word = '1;
      default: word = $urandom();
    endcase
    lo = (add_count > 24) ? add_count - 24 : 0;
    if ($urandom_range(0, 9) == 0) key = $urandom();
    else key = $urandom_range(add_count, lo);
    send_request(kind, word, key);
  endtask

  initial begin
    int profile;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty table, unknown ids, fill to full and add once more, then promote, lookup and pop
    send_request(KIND_POP, '1, '0);
    send_request(KIND_PROMOTE, '0, '1);
    send_request(KIND_LOOKUP, '1, '0);
    for (int i = 0; i < CAPACITY; i++)
      send_request(KIND_ADD, (i == 0) ? '0 : (i == 1) ? '1 : pay_t'($urandom()), '1);
    send_request(KIND_ADD, 32'h5a5a_a5a5, '0);
    send_request(KIND_PROMOTE, '0, 32'd5);
    send_request(KIND_LOOKUP, '0, 32'd5);
    send_request(KIND_LOOKUP, '0, 32'hffff_fff0);
    send_request(KIND_POP, '0, '0);
    send_request(KIND_POP, '0, '0);

    // raise one entry's priority with back to back promotes
    pace_en = 1'b0;
    rx_stall_en = 1'b0;
    for (int i = 0; i < 40; i++)
      send_request(KIND_PROMOTE, $urandom(), 32'd3);
    send_request(KIND_LOOKUP, '0, 32'd3);
    send_request(KIND_POP, '0, '0);
    end_burst();

    for (int b = 0; b < BLOCKS; b++) begin
      pace_en = (b % 4 != 3);
      rx_stall_en = pace_en;
      profile = (b == 0) ? 0 : $urandom_range(0, 2);
      for (int i = 0; i < BLOCK_ITEMS; i++) begin
        case (profile)
          0:       random_request(50, 25, 10);
          1:       random_request(15, 25, 45);
          default: random_request(30, 30, 25);
        endcase
      end
    end
    end_burst();

    rx_stall_en = 1'b1;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: promotable_priority_table.f
rtl/core/ppt_pkg.sv
rtl/core/ppt_scan.sv
rtl/core/promotable_priority_table.sv
test/ppt_outcome_checker.sv
test/promotable_priority_table_tb.sv
